FILE: src/waypoint_walker_step_top_assert.svh
// assertion macros for the waypoint walker
`ifndef WAYPOINT_WALKER_STEP_TOP_ASSERT_SVH
`define WAYPOINT_WALKER_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define WWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define WWS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define WWS_ASSERT(lbl, prop)
`define WWS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: src/wws_pkg.sv
`timescale 1ns / 1ps
package wws_pkg;

  localparam int ROUTE_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int SPEED_W = 10;
  localparam int LEN_W   = 7;
  localparam int HOME_W  = 16;
  localparam int ENTRY_W = 16;
  localparam int IDX_W   = 6;
  localparam int POS_W   = 24;
  localparam int PAUSE_W = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] REG_WALK_SPEED   = 2'd0;
  localparam logic [1:0] REG_ROUTE_LENGTH = 2'd1;
  localparam logic [1:0] REG_HOME_X       = 2'd2;
  localparam logic [1:0] REG_HOME_Y       = 2'd3;

endpackage

FILE: src/waypoint_walker_step_top.sv
`timescale 1ns / 1ps
`include "waypoint_walker_step_top_assert.svh"
// waypoint walker: one item per start pulse, one result per item
// input: start/busy command port; an item is taken when start is high and
//   busy is low. mode selects tick, route entry load or restart.
// result: out_valid marks the result for one cycle; the receiver cannot stall,
//   so the block never waits on the result side.
// config: apb-style port, registers walk_speed, route_length, home_x, home_y at
//   byte addresses 0, 4, 8, 12; write only while the block is idle.
// order: load, restart, finished-route and pause ticks give the result in the
//   cycle after the item. a tick reads the waypoint, forms the differences,
//   squares them and the speed (S_RD, S_DIFF, S_MX, S_MY, S_MS) and compares
//   (S_CMP); a tick that moves then takes the square root and, per axis, runs
//   S_DMUL, S_DIV and S_APPLY, on the shared multiplier and the one-bit-per-cycle
//   square root and restoring divide, which one tick walks through in turn.
// busy stays high while an item is in work; a new item can start in the cycle
//   its predecessor's result is shown.
// reset clears location, step and pause, sets walk_speed and route_length to 1
//   and clears home_x and home_y; the route table holds nothing until written.
module waypoint_walker_step_top #(
  parameter int ROUTE_DEPTH = wws_pkg::ROUTE_DEPTH_DEF,
  parameter int COORD_BITS  = wws_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = wws_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic [wws_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [wws_pkg::ENTRY_W-1:0]       in_entry_x,
  input  logic [wws_pkg::ENTRY_W-1:0]       in_entry_y,
  input  logic [wws_pkg::PAUSE_W-1:0]       in_pause_seconds,
  output logic                              out_valid,
  output logic [wws_pkg::POS_W-1:0]         out_pos_x,
  output logic [wws_pkg::POS_W-1:0]         out_pos_y,
  output logic [wws_pkg::LEN_W-1:0]         out_current_step,
  output logic [wws_pkg::PAUSE_W-1:0]       out_pause_left,
  output logic                              out_route_done,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wws_pkg::ADDR_W-1:0]        paddr,
  input  logic [wws_pkg::DATA_W-1:0]        pwdata,
  output logic [wws_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int AW  = $clog2(ROUTE_DEPTH);
  localparam int LW  = COORD_BITS + FRAC_BITS;
  localparam int SQW = wws_pkg::SPEED_W + FRAC_BITS;
  localparam int MW  = (LW > SQW) ? LW : SQW;
  localparam int PW  = 2 * MW;
  localparam int D2W = PW + 1;
  localparam int RW  = (D2W + 1) / 2;
  localparam int CW  = $clog2(PW + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_DIFF  = 11'b00000000100,
    S_MX    = 11'b00000001000,
    S_MY    = 11'b00000010000,
    S_MS    = 11'b00000100000,
    S_CMP   = 11'b00001000000,
    S_ROOT  = 11'b00010000000,
    S_DMUL  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_APPLY = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [wws_pkg::SPEED_W-1:0] speed_r;
  logic [wws_pkg::LEN_W-1:0]   len_r;
  logic [wws_pkg::HOME_W-1:0]  home_x_r, home_y_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= wws_pkg::SPEED_W'(1);
      len_r    <= wws_pkg::LEN_W'(1);
      home_x_r <= '0;
      home_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wws_pkg::REG_WALK_SPEED:   speed_r  <= pwdata[wws_pkg::SPEED_W-1:0];
        wws_pkg::REG_ROUTE_LENGTH: len_r    <= pwdata[wws_pkg::LEN_W-1:0];
        wws_pkg::REG_HOME_X:       home_x_r <= pwdata[wws_pkg::HOME_W-1:0];
        wws_pkg::REG_HOME_Y:       home_y_r <= pwdata[wws_pkg::HOME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wws_pkg::REG_WALK_SPEED:   prdata = wws_pkg::DATA_W'(speed_r);
      wws_pkg::REG_ROUTE_LENGTH: prdata = wws_pkg::DATA_W'(len_r);
      wws_pkg::REG_HOME_X:       prdata = wws_pkg::DATA_W'(home_x_r);
      wws_pkg::REG_HOME_Y:       prdata = wws_pkg::DATA_W'(home_y_r);
      default:                   prdata = '0;
    endcase
  end

  // walker state
  logic [LW-1:0]               loc_x_r, loc_y_r;
  logic [wws_pkg::LEN_W-1:0]   step_r;
  logic [wws_pkg::PAUSE_W-1:0] pause_r, pause_in_r;
  logic                        out_valid_r;

  // datapath
  logic [LW-1:0]  adx_r, ady_r;
  logic           xup_r, yup_r;
  logic [PW-1:0]  prod_r;
  logic [D2W-1:0] d2_r, res_r, bit_r;
  logic [RW-1:0]  rem_r;
  logic [CW-1:0]  cnt_r;
  logic           axis_r;

  logic [wws_pkg::LEN_W-1:0] eff_len;
  logic                      done;
  logic                      accept;

  assign eff_len = (32'(len_r) > 32'(ROUTE_DEPTH)) ? wws_pkg::LEN_W'(ROUTE_DEPTH) : len_r;
  assign done    = (step_r >= eff_len);
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;

  // route table
  logic                    mem_we;
  logic [2*COORD_BITS-1:0] mem_rdata;

  assign mem_we = accept && (in_mode == wws_pkg::MODE_LOAD)
                  && (32'(in_entry_index) < 32'(ROUTE_DEPTH));

  wws_route_mem #(
    .DEPTH (ROUTE_DEPTH),
    .WIDTH (2 * COORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_entry_index)),
    .wdata ({COORD_BITS'(in_entry_x), COORD_BITS'(in_entry_y)}),
    .raddr (AW'(step_r)),
    .rdata (mem_rdata)
  );

  // shared multiplier
  logic [MW-1:0] speed_q, mul_a, mul_b;
  logic [PW-1:0] mul_p;

  assign speed_q = MW'(speed_r) << FRAC_BITS;

  always_comb begin
    unique case (state_r)
      S_MX:    begin mul_a = MW'(adx_r); mul_b = MW'(adx_r); end
      S_MY:    begin mul_a = MW'(ady_r); mul_b = MW'(ady_r); end
      S_MS:    begin mul_a = speed_q;    mul_b = speed_q;    end
      default: begin
        mul_a = speed_q;
        mul_b = axis_r ? MW'(ady_r) : MW'(adx_r);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // target in fixed point and step helpers
  logic [LW-1:0]  tx, ty;
  logic [D2W-1:0] root_sum;
  logic [RW:0]    rem_sh;
  logic [RW-1:0]  mag;
  logic           q_bit;
  logic [LW-1:0]  ad_sel, delta, loc_sel, loc_new;
  logic           up_sel;

  assign tx       = {mem_rdata[2*COORD_BITS-1:COORD_BITS], FRAC_BITS'(0)};
  assign ty       = {mem_rdata[COORD_BITS-1:0], FRAC_BITS'(0)};
  assign root_sum = res_r + bit_r;
  assign mag      = res_r[RW-1:0];
  assign rem_sh   = {rem_r, prod_r[PW-1]};
  assign q_bit    = (rem_sh >= {1'b0, mag});
  assign ad_sel   = axis_r ? ady_r : adx_r;
  assign up_sel   = axis_r ? yup_r : xup_r;
  assign loc_sel  = axis_r ? loc_y_r : loc_x_r;
  assign delta    = (prod_r > PW'(ad_sel)) ? ad_sel : prod_r[LW-1:0];
  assign loc_new  = up_sel ? (loc_sel + delta) : (loc_sel - delta);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == wws_pkg::MODE_TICK) && !done && (pause_r == '0)) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_MS;
      S_MS:   state_nxt = S_CMP;
      S_CMP:  state_nxt = (d2_r < D2W'(prod_r)) ? S_IDLE : S_ROOT;
      S_ROOT: begin
        if (cnt_r == '0) begin
          // after the last step res holds the root once this edge lands
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: state_nxt = (mag == '0) ? S_IDLE : S_DIV;
      S_DIV:  state_nxt = (cnt_r == '0) ? S_APPLY : S_DIV;
      S_APPLY: state_nxt = axis_r ? S_IDLE : S_DMUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loc_x_r     <= '0;
      loc_y_r     <= '0;
      step_r      <= '0;
      pause_r     <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            priority if (in_mode == wws_pkg::MODE_TICK) begin
              if (done) begin
                out_valid_r <= 1'b1;
              end else if (pause_r != '0) begin
                pause_r     <= pause_r - 1'b1;
                out_valid_r <= 1'b1;
              end else begin
                pause_in_r <= in_pause_seconds;
              end
            end else if (in_mode == wws_pkg::MODE_RESTART) begin
              step_r      <= '0;
              pause_r     <= '0;
              loc_x_r     <= {COORD_BITS'(home_x_r), FRAC_BITS'(0)};
              loc_y_r     <= {COORD_BITS'(home_y_r), FRAC_BITS'(0)};
              out_valid_r <= 1'b1;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_DIFF: begin
          xup_r <= (tx >= loc_x_r);
          yup_r <= (ty >= loc_y_r);
          adx_r <= (tx >= loc_x_r) ? (tx - loc_x_r) : (loc_x_r - tx);
          ady_r <= (ty >= loc_y_r) ? (ty - loc_y_r) : (loc_y_r - ty);
        end
        S_MX: prod_r <= mul_p;
        S_MY: begin
          d2_r   <= D2W'(prod_r);
          prod_r <= mul_p;
        end
        S_MS: begin
          d2_r   <= d2_r + D2W'(prod_r);
          prod_r <= mul_p;
        end
        S_CMP: begin
          if (d2_r < D2W'(prod_r)) begin
            pause_r     <= pause_in_r;
            step_r      <= step_r + 1'b1;
            out_valid_r <= 1'b1;
          end else begin
            res_r <= '0;
            bit_r <= D2W'(1) << (2 * (RW - 1));
            cnt_r <= CW'(RW - 1);
          end
        end
        S_ROOT: begin
          if (d2_r >= root_sum) begin
            d2_r  <= d2_r - root_sum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          cnt_r  <= cnt_r - 1'b1;
          axis_r <= 1'b0;
        end
        S_DMUL: begin
          prod_r <= mul_p;
          rem_r  <= '0;
          cnt_r  <= CW'(PW - 1);
          if (mag == '0) begin
            out_valid_r <= 1'b1;
          end
        end
        S_DIV: begin
          // restoring divide, quotient shifts in from the bottom
          if (q_bit) begin
            rem_r <= RW'(rem_sh - {1'b0, mag});
          end else begin
            rem_r <= rem_sh[RW-1:0];
          end
          prod_r <= {prod_r[PW-2:0], q_bit};
          cnt_r  <= cnt_r - 1'b1;
        end
        S_APPLY: begin
          if (axis_r) begin
            loc_y_r     <= loc_new;
            out_valid_r <= 1'b1;
          end else begin
            loc_x_r <= loc_new;
          end
          axis_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = wws_pkg::POS_W'(loc_x_r);
  assign out_pos_y        = wws_pkg::POS_W'(loc_y_r);
  assign out_current_step = step_r;
  assign out_pause_left   = pause_r;
  assign out_route_done   = done;

  `WWS_ASSERT(a_state_onehot, $onehot(state_r))
  `WWS_ASSERT(a_result_when_idle, out_valid_r |-> (state_r == S_IDLE))
  `WWS_ASSERT(a_item_makes_progress, (start && !busy) |=> (busy || out_valid))
  `WWS_ASSERT(a_step_moves_by_one, (step_r != $past(step_r) && step_r != '0) |->
    (step_r == $past(step_r) + 1'b1))

endmodule

FILE: src/wws_route_mem.sv
`timescale 1ns / 1ps
module wws_route_mem #(
  parameter int DEPTH = wws_pkg::ROUTE_DEPTH_DEF,
  parameter int WIDTH = 2 * wws_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/tb_waypoint_walker_step_top.sv
`timescale 1ns / 1ps
module tb_waypoint_walker_step_top;

  localparam int DEPTH = wws_pkg::ROUTE_DEPTH_DEF;
  localparam int FRAC = wws_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 1300;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [wws_pkg::POS_W-1:0] px;
    logic [wws_pkg::POS_W-1:0] py;
    logic [wws_pkg::LEN_W-1:0] step;
    logic [wws_pkg::PAUSE_W-1:0] pause;
    logic done;
  } walk_res_t;

  typedef struct {
    logic [1:0] mode;
    logic [wws_pkg::IDX_W-1:0] idx;
    logic [wws_pkg::ENTRY_W-1:0] ex;
    logic [wws_pkg::ENTRY_W-1:0] ey;
    logic [wws_pkg::PAUSE_W-1:0] pause;
    bit typed;
    walk_res_t res;
  } walk_row_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_mode;
  logic [wws_pkg::IDX_W-1:0] in_entry_index;
  logic [wws_pkg::ENTRY_W-1:0] in_entry_x, in_entry_y;
  logic [wws_pkg::PAUSE_W-1:0] in_pause_seconds;
  logic out_valid;
  logic [wws_pkg::POS_W-1:0] out_pos_x, out_pos_y;
  logic [wws_pkg::LEN_W-1:0] out_current_step;
  logic [wws_pkg::PAUSE_W-1:0] out_pause_left;
  logic out_route_done;
  logic psel, penable, pwrite, pready;
  logic [wws_pkg::ADDR_W-1:0] paddr;
  logic [wws_pkg::DATA_W-1:0] pwdata, prdata;

  waypoint_walker_step_top dut (.*);

  // walker model state
  logic [wws_pkg::ENTRY_W-1:0] wp_x [DEPTH];
  logic [wws_pkg::ENTRY_W-1:0] wp_y [DEPTH];
  bit wp_written [DEPTH];
  logic [wws_pkg::POS_W-1:0] w_x, w_y;
  logic [wws_pkg::LEN_W-1:0] w_step;
  logic [wws_pkg::PAUSE_W-1:0] w_pause;
  logic [wws_pkg::SPEED_W-1:0] speed_reg;
  logic [wws_pkg::LEN_W-1:0] len_reg;
  logic [wws_pkg::HOME_W-1:0] home_x_reg, home_y_reg;

  walk_res_t walk_q[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  bit no_idle = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int route_len_eff();
    return (len_reg > DEPTH) ? DEPTH : int'(len_reg);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [wws_pkg::POS_W-1:0] step_axis(longint unsigned loc,
                                                          longint unsigned tgt,
                                                          longint unsigned spd,
                                                          longint unsigned mag);
    longint unsigned ad, delta;
    if (mag == 0) return wws_pkg::POS_W'(loc);
    ad = (tgt >= loc) ? tgt - loc : loc - tgt;
    delta = (spd * ad) / mag;
    if (delta > ad) delta = ad;
    return (tgt >= loc) ? wws_pkg::POS_W'(loc + delta) : wws_pkg::POS_W'(loc - delta);
  endfunction

  function automatic walk_res_t walk_predict(walk_row_t r);
    longint unsigned tx, ty, adx, ady, d2, spd, mag;
    walk_res_t res;
    case (r.mode)
      wws_pkg::MODE_TICK: begin
        if (w_step < route_len_eff()) begin
          if (w_pause > 0) begin
            w_pause--;
          end else begin
            tx = longint'(wp_x[w_step]) << FRAC;
            ty = longint'(wp_y[w_step]) << FRAC;
            adx = (tx >= w_x) ? tx - w_x : w_x - tx;
            ady = (ty >= w_y) ? ty - w_y : w_y - ty;
            d2 = adx * adx + ady * ady;
            spd = longint'(speed_reg) << FRAC;
            if (d2 < spd * spd) begin
              w_pause = r.pause;
              w_step++;
            end else begin
              mag = int_sqrt(d2);
              w_x = step_axis(longint'(w_x), tx, spd, mag);
              w_y = step_axis(longint'(w_y), ty, spd, mag);
            end
          end
        end
      end
      wws_pkg::MODE_LOAD: begin
        wp_x[r.idx] = r.ex;
        wp_y[r.idx] = r.ey;
        wp_written[r.idx] = 1;
      end
      wws_pkg::MODE_RESTART: begin
        w_step = 0;
        w_pause = 0;
        w_x = {home_x_reg, {FRAC{1'b0}}};
        w_y = {home_y_reg, {FRAC{1'b0}}};
      end
      default: ;
    endcase
    res.px = w_x;
    res.py = w_y;
    res.step = w_step;
    res.pause = w_pause;
    res.done = (w_step >= route_len_eff());
    return res;
  endfunction

  task automatic idle_gap();
    int g;
    int roll = $urandom_range(0, 99);
    if (no_idle || roll < 40) g = 0;
    else if (roll < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      start <= 0;
      psel <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_item(walk_row_t r);
    walk_res_t pred;
    idle_gap();
    start <= 1;
    in_mode <= r.mode;
    in_entry_index <= r.idx;
    in_entry_x <= r.ex;
    in_entry_y <= r.ey;
    in_pause_seconds <= r.pause;
    do @(posedge clk); while (busy);
    pred = walk_predict(r);
    walk_q.insert(walk_q.size(), r.typed ? r.res : pred);
    if (r.mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send(logic [1:0] m, int idx, int ex, int ey, int p);
    walk_row_t r;
    r.mode = m;
    r.idx = wws_pkg::IDX_W'(idx);
    r.ex = wws_pkg::ENTRY_W'(ex);
    r.ey = wws_pkg::ENTRY_W'(ey);
    r.pause = wws_pkg::PAUSE_W'(p);
    r.typed = 0;
    r.res = '0;
    send_item(r);
  endtask

  task automatic drain();
    start <= 0;
    while (walk_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, int val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      wws_pkg::REG_WALK_SPEED: speed_reg = wws_pkg::SPEED_W'(val);
      wws_pkg::REG_ROUTE_LENGTH: len_reg = wws_pkg::LEN_W'(val);
      wws_pkg::REG_HOME_X: home_x_reg = wws_pkg::HOME_W'(val);
      default: home_y_reg = wws_pkg::HOME_W'(val);
    endcase
    // bus idle cycle between transfers
    @(posedge clk);
  endtask

  function automatic int near(int c, int span);
    int v = c + $urandom_range(0, 2 * span) - span;
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  function automatic int pick_pause();
    int roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 20);
    return $urandom_range(0, 65535);
  endfunction

  // never let a tick read a waypoint that was not loaded
  task automatic tick_or_fill(int span);
    if (w_step < route_len_eff() && !wp_written[w_step])
      send(wws_pkg::MODE_LOAD, w_step, near(w_x >> FRAC, span), near(w_y >> FRAC, span), 0);
    else
      send(wws_pkg::MODE_TICK, $urandom_range(0, 63), $urandom, $urandom, pick_pause());
  endtask

  walk_row_t dir_rows[$];

  function automatic void queue_row(walk_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic walk_row_t row(logic [1:0] m, int idx, int ex, int ey, int p,
                                    bit typed, walk_res_t res);
    walk_row_t r;
    r.mode = m;
    r.idx = wws_pkg::IDX_W'(idx);
    r.ex = wws_pkg::ENTRY_W'(ex);
    r.ey = wws_pkg::ENTRY_W'(ey);
    r.pause = wws_pkg::PAUSE_W'(p);
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  always @(posedge clk) begin
    walk_res_t e;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (walk_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time,
                 {out_pos_x, out_pos_y, out_current_step, out_pause_left, out_route_done});
        errors++;
      end else begin
        e = walk_q.pop_front();
        if (out_pos_x !== e.px) begin
          $display("%0t: pos_x expected %h got %h", $time, e.px, out_pos_x);
          errors++;
        end
        if (out_pos_y !== e.py) begin
          $display("%0t: pos_y expected %h got %h", $time, e.py, out_pos_y);
          errors++;
        end
        if (out_current_step !== e.step) begin
          $display("%0t: current_step expected %0d got %0d", $time, e.step, out_current_step);
          errors++;
        end
        if (out_pause_left !== e.pause) begin
          $display("%0t: pause_left expected %0d got %0d", $time, e.pause, out_pause_left);
          errors++;
        end
        if (out_route_done !== e.done) begin
          $display("%0t: route_done expected %0d got %0d", $time, e.done, out_route_done);
          errors++;
        end
      end
    end
  end

  initial begin
    int len, spd, hx, hy, span, n;
    rst_n = 0;
    start = 0;
    in_mode = wws_pkg::MODE_TICK;
    in_entry_index = 0;
    in_entry_x = 0;
    in_entry_y = 0;
    in_pause_seconds = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    for (int i = 0; i < DEPTH; i++) begin
      wp_x[i] = 0;
      wp_y[i] = 0;
      wp_written[i] = 0;
    end
    w_x = 0;
    w_y = 0;
    w_step = 0;
    w_pause = 0;
    speed_reg = 1;
    len_reg = 1;
    home_x_reg = 0;
    home_y_reg = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset state, unused mode, arrival with full pause, finished route
    queue_row(row(MODE_UNUSED, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
    queue_row(row(wws_pkg::MODE_RESTART, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
    queue_row(row(wws_pkg::MODE_LOAD, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
    queue_row(row(wws_pkg::MODE_TICK, 0, 0, 0, 16'hffff, 1, '{0, 0, 1, 16'hffff, 1}));
    queue_row(row(wws_pkg::MODE_TICK, 63, 16'hffff, 16'hffff, 7, 1,
                  '{0, 0, 1, 16'hffff, 1}));
    queue_row(row(wws_pkg::MODE_LOAD, 63, 16'hffff, 16'hffff, 0, 1,
                  '{0, 0, 1, 16'hffff, 1}));
    queue_row(row(wws_pkg::MODE_RESTART, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
    queue_row(row(wws_pkg::MODE_LOAD, 0, 3, 4, 0, 1, '{0, 0, 0, 0, 0}));
    for (int i = 0; i < 6; i++) queue_row(row(wws_pkg::MODE_TICK, 0, 0, 0, 2, 0, '0));
    queue_row(row(MODE_UNUSED, 63, 16'hffff, 16'hffff, 16'hffff, 0, '0));
    queue_row(row(wws_pkg::MODE_LOAD, 0, 16'hffff, 16'hffff, 0, 0, '0));
    for (int i = 0; i < 4; i++) queue_row(row(wws_pkg::MODE_TICK, 0, 0, 0, 0, 0, '0));
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();

    // random phases: configure, lay a route near home, restart, then walk it
    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (ph % 8)
        0: begin spd = 1023; len = 127; end
        1: begin spd = 0; len = 2; end
        2: begin spd = 1; len = 0; end
        3: begin spd = $urandom_range(1, 1023); len = 64; end
        default: begin spd = $urandom_range(2, 60); len = $urandom_range(1, 8); end
      endcase
      case ($urandom_range(0, 3))
        0: begin hx = 0; hy = 65535; end
        1: begin hx = 65535; hy = 0; end
        default: begin hx = $urandom_range(0, 65535); hy = $urandom_range(0, 65535); end
      endcase
      reg_write(wws_pkg::REG_WALK_SPEED, spd);
      reg_write(wws_pkg::REG_ROUTE_LENGTH, len);
      reg_write(wws_pkg::REG_HOME_X, hx);
      reg_write(wws_pkg::REG_HOME_Y, hy);
      span = (spd == 0) ? 3 : spd * $urandom_range(1, 8);
      for (int i = 0; i < route_len_eff() && i < 8; i++)
        send(wws_pkg::MODE_LOAD, i, near(hx, span), near(hy, span), 0);
      send(wws_pkg::MODE_RESTART, $urandom_range(0, 63), $urandom, $urandom, $urandom);
      n = $urandom_range(30, 60);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 19))
          0: send(MODE_UNUSED, $urandom_range(0, 63), $urandom, $urandom, $urandom);
          1: send(wws_pkg::MODE_LOAD, $urandom_range(0, 63), $urandom, $urandom, $urandom);
          2: send(wws_pkg::MODE_RESTART, $urandom_range(0, 63), $urandom, $urandom, $urandom);
          default: tick_or_fill(span);
        endcase
      end
      drain();
    end

    drain();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/wws_pkg.sv
src/wws_route_mem.sv
src/waypoint_walker_step_top.sv
tb/sv/tb_waypoint_walker_step_top.sv
